// File: hdl/tfn_pkg.sv
// Shared constants and status types for the triangle face normal block.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int NORM_TOP = 29;
  localparam int NORM_W   = NORM_TOP + 1;
  localparam int SQR_W    = 2 * NORM_W;
  localparam int SUM_W    = SQR_W + 2;
  localparam int LEN_W    = SUM_W / 2;
  localparam int SQ_STAGES = LEN_W;

  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_POS_SAT = 16'h7fff;
  localparam logic [OUT_W-1:0] OUT_NEG_SAT = 16'h8000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  typedef struct packed {
    logic [1:0] inflight;
  } tfn_front_stat_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } tfn_queue_stat_t;

endpackage
`default_nettype wire

// File: hdl/tfn_front.sv
// Front part: edge vectors and cross product of each accepted triangle.
`timescale 1ns / 1ps
`default_nettype none
module tfn_front #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   take,
  input  wire [COORD_BITS-1:0]  ax,
  input  wire [COORD_BITS-1:0]  ay,
  input  wire [COORD_BITS-1:0]  az,
  input  wire [COORD_BITS-1:0]  bx,
  input  wire [COORD_BITS-1:0]  by,
  input  wire [COORD_BITS-1:0]  bz,
  input  wire [COORD_BITS-1:0]  cx,
  input  wire [COORD_BITS-1:0]  cy,
  input  wire [COORD_BITS-1:0]  cz,
  output logic                  push,
  output logic [3*(2*((COORD_BITS > tfn_pkg::NORM_TOP) ? tfn_pkg::NORM_TOP : COORD_BITS)+3):0]
                                push_data,
  output tfn_pkg::tfn_front_stat_t stat
);

  localparam int PRE = (COORD_BITS > tfn_pkg::NORM_TOP) ? COORD_BITS - tfn_pkg::NORM_TOP : 0;
  localparam int DW  = COORD_BITS - PRE + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = 2 * DW + 1;

  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];
  logic signed [COORD_BITS:0]   e1 [3];
  logic signed [COORD_BITS:0]   e2 [3];
  logic signed [DW-1:0] d1_next [3];
  logic signed [DW-1:0] d2_next [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [PW-1:0] pr [6];
  logic signed [CW-1:0] n [3];
  logic v1, v2, v3;
  logic dg;

  always_comb begin
    va[0] = ax; va[1] = ay; va[2] = az;
    vb[0] = bx; vb[1] = by; vb[2] = bz;
    vc[0] = cx; vc[1] = cy; vc[2] = cz;
    for (int k = 0; k < 3; k++) begin
      e1[k] = (COORD_BITS+1)'(va[k]) - (COORD_BITS+1)'(vb[k]);
      e2[k] = (COORD_BITS+1)'(vb[k]) - (COORD_BITS+1)'(vc[k]);
      e1[k] = e1[k] >>> PRE;
      e2[k] = e2[k] >>> PRE;
      d1_next[k] = e1[k][DW-1:0];
      d2_next[k] = e2[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d1 <= d1_next;
    d2 <= d2_next;
    pr[0] <= d1[1] * d2[2];
    pr[1] <= d1[2] * d2[1];
    pr[2] <= d1[2] * d2[0];
    pr[3] <= d1[0] * d2[2];
    pr[4] <= d1[0] * d2[1];
    pr[5] <= d1[1] * d2[0];
    for (int k = 0; k < 3; k++) begin
      n[k] <= CW'(pr[2*k]) - CW'(pr[2*k+1]);
    end
  end

  assign dg = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  assign push = v3;
  assign push_data = {dg, n[2], n[1], n[0]};
  assign stat.inflight = 2'(v1) + 2'(v2) + 2'(v3);

endmodule
`default_nettype wire

// File: hdl/tfn_queue.sv
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module tfn_queue #(
  parameter int W = 100
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire [W-1:0]  push_data,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  output tfn_pkg::tfn_queue_stat_t stat
);

  logic [W-1:0] mem [tfn_pkg::QUEUE_DEPTH];
  logic [tfn_pkg::QPTR_W-1:0] wr, rd;
  logic [tfn_pkg::QLVL_W-1:0] level;
  logic pop;

  assign pop       = (level != '0);
  assign pop_valid = pop;
  assign pop_data  = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      level <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      level <= level + tfn_pkg::QLVL_W'(push) - tfn_pkg::QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_data;
  end

  assign stat.empty = (level == '0);
  assign stat.level = level;

endmodule
`default_nettype wire

// File: hdl/tfn_back.sv
// Back part: normalise, square-root length, divide and saturate.
`timescale 1ns / 1ps
`default_nettype none
module tfn_back #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tfn_pkg::FRAC_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire [3*(2*((COORD_BITS > tfn_pkg::NORM_TOP) ? tfn_pkg::NORM_TOP : COORD_BITS)+3):0]
                     in_data,
  output logic       done,
  output logic [tfn_pkg::OUT_W-1:0] norm_x,
  output logic [tfn_pkg::OUT_W-1:0] norm_y,
  output logic [tfn_pkg::OUT_W-1:0] norm_z,
  output logic       degenerate
);

  localparam int PRE  = (COORD_BITS > tfn_pkg::NORM_TOP) ? COORD_BITS - tfn_pkg::NORM_TOP : 0;
  localparam int DW   = COORD_BITS - PRE + 1;
  localparam int CW   = 2 * DW + 1;
  localparam int MW   = 2 * DW;
  localparam int PBW  = $clog2(MW);
  localparam int XW   = (MW > tfn_pkg::NORM_W) ? MW : tfn_pkg::NORM_W;
  localparam int NW   = tfn_pkg::NORM_W;
  localparam int S    = tfn_pkg::SQ_STAGES;
  localparam int SW   = tfn_pkg::SUM_W;
  localparam int LW   = tfn_pkg::LEN_W;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NUMW = NW + FRAC_BITS + 1;
  localparam int TW   = (QW > tfn_pkg::OUT_W + 1) ? QW : tfn_pkg::OUT_W + 1;

  logic signed [CW-1:0] n_in [3];
  logic [MW-1:0] b1_mag [3];
  logic [2:0]    b1_neg, b2_neg, b3_neg, b4_neg, b5_neg;
  logic          b1_dg, b2_dg, b3_dg, b4_dg, b5_dg;
  logic          b1_v, b2_v, b3_v, b4_v, b5_v;
  logic [MW-1:0] b2_mag [3];
  logic [MW-1:0] lead_or;
  logic [PBW-1:0] lead_next, b2_lead;
  logic [XW-1:0] ext [3];
  logic [NW-1:0] b3_m [3];
  logic [NW-1:0] b4_m [3];
  logic [NW-1:0] b5_m [3];
  logic [tfn_pkg::SQR_W-1:0] b4_sq [3];
  logic [SW-1:0] b5_sum;

  logic [SW-1:0] sq_x   [0:S];
  logic [SW-1:0] sq_r   [0:S];
  logic [NW-1:0] sq_m   [0:S][3];
  logic [2:0]    sq_neg [0:S];
  logic          sq_dg  [0:S];
  logic          sq_v   [0:S];

  logic [NUMW-1:0] dv_r   [0:QW][3];
  logic [QW-1:0]   dv_q   [0:QW][3];
  logic [LW-1:0]   dv_len [0:QW];
  logic [2:0]      dv_neg [0:QW];
  logic            dv_dg  [0:QW];
  logic            dv_v   [0:QW];

  logic [tfn_pkg::OUT_W-1:0] res_next [3];
  logic [TW-1:0] qe [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_in[k] = in_data[k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0; b2_v <= 1'b0; b3_v <= 1'b0; b4_v <= 1'b0; b5_v <= 1'b0;
    end else begin
      b1_v <= in_valid; b2_v <= b1_v; b3_v <= b2_v; b4_v <= b3_v; b5_v <= b4_v;
    end
  end

  always_comb begin
    lead_or = b1_mag[0] | b1_mag[1] | b1_mag[2];
    lead_next = '0;
    for (int i = 0; i < MW; i++) begin
      if (lead_or[i]) lead_next = PBW'(i);
    end
    for (int k = 0; k < 3; k++) begin
      ext[k] = XW'(b2_mag[k]);
      if (int'(b2_lead) > tfn_pkg::NORM_TOP) begin
        ext[k] = ext[k] >> (int'(b2_lead) - tfn_pkg::NORM_TOP);
      end else begin
        ext[k] = ext[k] << (tfn_pkg::NORM_TOP - int'(b2_lead));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      b1_mag[k] <= n_in[k][CW-1] ? MW'(-n_in[k]) : MW'(n_in[k]);
      b1_neg[k] <= n_in[k][CW-1];
      b2_mag[k] <= b1_mag[k];
      b3_m[k]   <= ext[k][NW-1:0];
      b4_m[k]   <= b3_m[k];
      b4_sq[k]  <= b3_m[k] * b3_m[k];
      b5_m[k]   <= b4_m[k];
    end
    b1_dg   <= in_data[3*CW];
    b2_lead <= lead_next;
    b2_neg  <= b1_neg; b3_neg <= b2_neg; b4_neg <= b3_neg; b5_neg <= b4_neg;
    b2_dg   <= b1_dg;  b3_dg  <= b2_dg;  b4_dg  <= b3_dg;  b5_dg  <= b4_dg;
    b5_sum  <= SW'(b4_sq[0]) + SW'(b4_sq[1]) + SW'(b4_sq[2]);
  end

  always_comb begin
    sq_x[0]   = b5_sum;
    sq_r[0]   = '0;
    sq_m[0]   = b5_m;
    sq_neg[0] = b5_neg;
    sq_dg[0]  = b5_dg;
    sq_v[0]   = b5_v;
  end

  for (genvar j = 0; j < S; j++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (S - 1 - j));
    logic [SW-1:0] trial;
    assign trial = sq_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else     sq_v[j+1] <= sq_v[j];
    end
    always_ff @(posedge clk) begin
      if (sq_x[j] >= trial) begin
        sq_x[j+1] <= sq_x[j] - trial;
        sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
      end else begin
        sq_x[j+1] <= sq_x[j];
        sq_r[j+1] <= sq_r[j] >> 1;
      end
      sq_m[j+1]   <= sq_m[j];
      sq_neg[j+1] <= sq_neg[j];
      sq_dg[j+1]  <= sq_dg[j];
    end
  end

  always_comb begin
    dv_len[0] = sq_r[S][LW-1:0];
    for (int k = 0; k < 3; k++) begin
      dv_r[0][k] = (NUMW'(sq_m[S][k]) << FRAC_BITS) + NUMW'(dv_len[0] >> 1);
      dv_q[0][k] = '0;
    end
    dv_neg[0] = sq_neg[S];
    dv_dg[0]  = sq_dg[S];
    dv_v[0]   = sq_v[S];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [NUMW-1:0] dsh;
    assign dsh = NUMW'(dv_len[j]) << SH;
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else     dv_v[j+1] <= dv_v[j];
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_r[j][k] >= dsh) begin
          dv_r[j+1][k] <= dv_r[j][k] - dsh;
          dv_q[j+1][k] <= dv_q[j][k] | (QW'(1) << SH);
        end else begin
          dv_r[j+1][k] <= dv_r[j][k];
          dv_q[j+1][k] <= dv_q[j][k];
        end
      end
      dv_len[j+1] <= dv_len[j];
      dv_neg[j+1] <= dv_neg[j];
      dv_dg[j+1]  <= dv_dg[j];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qe[k] = TW'(dv_q[QW][k]);
      priority if (dv_dg[QW]) begin
        res_next[k] = '0;
      end else if (dv_neg[QW][k]) begin
        if (qe[k] > TW'(32768)) res_next[k] = tfn_pkg::OUT_NEG_SAT;
        else                    res_next[k] = tfn_pkg::OUT_W'(-qe[k]);
      end else begin
        if (qe[k] > TW'(32767)) res_next[k] = tfn_pkg::OUT_POS_SAT;
        else                    res_next[k] = qe[k][tfn_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    norm_x     <= res_next[0];
    norm_y     <= res_next[1];
    norm_z     <= res_next[2];
    degenerate <= dv_dg[QW];
  end

endmodule
`default_nettype wire

// File: hdl/triangle_face_normal_top.sv
// Top level of the triangle face normal block.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------
//  command  | start / busy      | ax ay az bx by bz cx cy cz
//  result   | done (one cycle)  | norm_x norm_y norm_z degenerate
//
// One triangle a cycle while busy is low; the path runs through 3 front stages, one queue
// slot, 5 normalise stages, LEN_W square-root stages, FRAC_BITS+1 divide stages and an
// output register.
// The square-root and divide chains, one bit per stage, set the latency.
// Synchronous reset empties the pipeline and queue; busy rises only when the
// queue could overflow, which a draining back part never lets happen.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_top #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tfn_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire [COORD_BITS-1:0]  ax,
  input  wire [COORD_BITS-1:0]  ay,
  input  wire [COORD_BITS-1:0]  az,
  input  wire [COORD_BITS-1:0]  bx,
  input  wire [COORD_BITS-1:0]  by,
  input  wire [COORD_BITS-1:0]  bz,
  input  wire [COORD_BITS-1:0]  cx,
  input  wire [COORD_BITS-1:0]  cy,
  input  wire [COORD_BITS-1:0]  cz,
  output logic                  done,
  output logic [tfn_pkg::OUT_W-1:0] norm_x,
  output logic [tfn_pkg::OUT_W-1:0] norm_y,
  output logic [tfn_pkg::OUT_W-1:0] norm_z,
  output logic                  degenerate
);

  localparam int DW = ((COORD_BITS > tfn_pkg::NORM_TOP) ? tfn_pkg::NORM_TOP : COORD_BITS) + 1;
  localparam int QW = 3 * (2 * DW + 1) + 1;

  tfn_pkg::tfn_front_stat_t front_stat;
  tfn_pkg::tfn_queue_stat_t queue_stat;
  logic          take;
  logic          push;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic [QW-1:0] pop_data;

  assign busy = (queue_stat.level + tfn_pkg::QLVL_W'(front_stat.inflight))
                > tfn_pkg::QLVL_W'(tfn_pkg::QUEUE_DEPTH);
  assign take = start & ~busy;

  tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .take(take),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .cx(cx), .cy(cy), .cz(cz),
    .push(push), .push_data(push_data), .stat(front_stat)
  );

  tfn_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop_valid(pop_valid), .pop_data(pop_data), .stat(queue_stat)
  );

  tfn_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(pop_valid), .in_data(pop_data),
    .done(done), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

endmodule
`default_nettype wire

// File: hdl/tfn_checker.sv
// Port-level checks for the triangle face normal block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tfn_port_checks (
  input wire                        clk,
  input wire                        rst,
  input wire                        busy,
  input wire                        done,
  input wire [tfn_pkg::OUT_W-1:0]   norm_x,
  input wire [tfn_pkg::OUT_W-1:0]   norm_y,
  input wire [tfn_pkg::OUT_W-1:0]   norm_z,
  input wire                        degenerate
);

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate result with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> norm_x != '0 || norm_y != '0 || norm_z != '0)
    else $error("zero normal without degenerate flag");

  a_reset_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_reset_busy: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

endmodule

bind triangle_face_normal_top tfn_port_checks u_tfn_port_checks (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate)
);
`default_nettype wire

// File: tb/tfn_checker.sv
// Checker for the triangle face normal block: predicts each normal and compares results.
`timescale 1ns / 1ps
module tfn_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire        busy,
  input  wire [15:0] ax, ay, az, bx, by, bz, cx, cy, cz,
  input  wire        done,
  input  wire [15:0] norm_x, norm_y, norm_z,
  input  wire        degenerate,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] saturate(logic [63:0] q, bit neg);
    if (neg) return (q > 64'd32768) ? 16'h8000 : 16'(-q);
    return (q > 64'd32767) ? 16'h7fff : q[15:0];
  endfunction

  function automatic normal_t face_normal(logic signed [15:0] a[3], logic signed [15:0] b[3],
                                          logic signed [15:0] c[3]);
    longint d1[3], d2[3], n[3];
    logic [63:0] m[3];
    logic [63:0] top, len, q;
    int p;
    normal_t r;
    for (int k = 0; k < 3; k++) begin
      d1[k] = longint'(a[k]) - longint'(b[k]);
      d2[k] = longint'(b[k]) - longint'(c[k]);
    end
    n[0] = d1[1] * d2[2] - d1[2] * d2[1];
    n[1] = d1[2] * d2[0] - d1[0] * d2[2];
    n[2] = d1[0] * d2[1] - d1[1] * d2[0];
    r = '0;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.degen = 1'b1;
      return r;
    end
    top = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = (n[k] < 0) ? -n[k] : n[k];
      if (m[k] > top) top = m[k];
    end
    p = 0;
    while (p < 63 && (top >> (p + 1)) != 0) p++;
    for (int k = 0; k < 3; k++)
      m[k] = (p > 29) ? (m[k] >> (p - 29)) : (m[k] << (29 - p));
    len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (len == 0) len = 1;
    q = ((m[0] << 14) + (len >> 1)) / len;
    r.nx = saturate(q, n[0] < 0);
    q = ((m[1] << 14) + (len >> 1)) / len;
    r.ny = saturate(q, n[1] < 0);
    q = ((m[2] << 14) + (len >> 1)) / len;
    r.nz = saturate(q, n[2] < 0);
    return r;
  endfunction

  assign pending = expected_normals.size();

  always @(posedge clk) begin
    normal_t e;
    int bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy)
        expected_normals.push_back(face_normal('{ax, ay, az}, '{bx, by, bz}, '{cx, cy, cz}));
      if (done) begin
        if (expected_normals.size() == 0) begin
          $error("result transfer with nothing expected");
          bad++;
        end else begin
          e = expected_normals.pop_front();
          if (norm_x !== e.nx) begin
            $error("norm_x expected %0d actual %0d", $signed(e.nx), $signed(norm_x));
            bad++;
          end
          if (norm_y !== e.ny) begin
            $error("norm_y expected %0d actual %0d", $signed(e.ny), $signed(norm_y));
            bad++;
          end
          if (norm_z !== e.nz) begin
            $error("norm_z expected %0d actual %0d", $signed(e.nz), $signed(norm_z));
            bad++;
          end
          if (degenerate !== e.degen) begin
            $error("degenerate expected %0b actual %0b", e.degen, degenerate);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

endmodule

// File: tb/tb_triangle_face_normal_top.sv
// Testbench top for the triangle face normal block: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb_triangle_face_normal_top;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [15:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0, cx = 0, cy = 0, cz = 0;
  wire busy, done, degenerate;
  wire [15:0] norm_x, norm_y, norm_z;
  int errors, pending;
  int cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  triangle_face_normal_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .cx(cx), .cy(cy), .cz(cz),
    .done(done), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate)
  );

  tfn_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .cx(cx), .cy(cy), .cz(cz),
    .done(done), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [15:0] coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // hold the triangle until the transfer happens
  task automatic send(logic [15:0] v[9]);
    start <= 1;
    {ax, ay, az, bx, by, bz, cx, cy, cz} <= {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7],
                                             v[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [15:0] v[9];
    int burst, mode;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // extremes, coincident, collinear and axis-aligned triangles
    send('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0});
    send('{16'h8000, 16'h7fff, 16'h0, 16'h7fff, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h7fff});
    send('{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5});
    send('{16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6});
    send('{16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff});
    send('{16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0});
    send('{16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384});
    send('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0});
    send('{16'hffff, 16'h0, 16'h1, 16'h1, 16'hffff, 16'h0, 16'h0, 16'h1, 16'hffff});
    send('{16'h8000, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h7fff});
    // drain fully before the random part
    pause(1);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 1000; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && i < 1000; j++, i++) begin
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) v[k] = coord(mode < 6 ? 4 : $urandom_range(0, 4));
        if (mode == 9) v[6] = v[3];
        if (mode == 9) begin
          v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
        end
        send(v);
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
